FILE: sv/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion pipeline.
// No dependencies; used by rmq_stage and rotation_matrix_to_quaternion.
package rmq_pkg;

    // Q2.14 unit and stage layout
    localparam logic [15:0] ONE_Q14    = 16'h4000;
    localparam int          SQRT_STAGES = 4;
    localparam int          DIV_STAGES  = 4;
    localparam int          STEPS       = 4;
    localparam int          NUM_STAGES  = 1 + SQRT_STAGES + 1 + DIV_STAGES + 1;

    // Stage kinds
    localparam int KIND_PREP = 0;
    localparam int KIND_SQRT = 1;
    localparam int KIND_DSET = 2;
    localparam int KIND_DIV  = 3;
    localparam int KIND_OUT  = 4;

    // Which component comes from the root
    typedef enum logic [1:0] {
        SEL_W = 2'd0,
        SEL_X = 2'd1,
        SEL_Y = 2'd2,
        SEL_Z = 2'd3
    } t_sel;

    // Item state carried down the pipeline
    typedef struct packed {
        t_sel               sel;
        logic               degen;
        logic [2:0][16:0]   num;     // signed numerators
        logic [31:0]        sq_rem;
        logic [31:0]        sq_res;
        logic [15:0]        half;
        logic [16:0]        dv;      // divisor 2q
        logic [2:0]         neg;
        logic [2:0]         ovf;
        logic [2:0][16:0]   rem;
        logic [2:0][15:0]   lo;      // dividend bits out, quotient bits in
        logic [3:0][15:0]   qo;      // x, y, z, w
    } t_pipe;

endpackage

FILE: sv/rmq_stage.sv
// One register stage of the quaternion pipeline; KIND picks its work.
// Depends on rmq_pkg.
module rmq_stage #(
    parameter int KIND = 0,
    parameter int STEP = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vld,
    output logic                  o_rdy,
    input  rmq_pkg::t_pipe        i_data,
    input  logic [8:0][15:0]      i_mat,
    output logic                  o_vld,
    input  logic                  i_rdy,
    output rmq_pkg::t_pipe        o_data
);
    import rmq_pkg::*;

    logic                r_vld;
    t_pipe               r_data;
    t_pipe               n_data;
    logic signed [15:0]  m [9];
    logic signed [17:0]  trace;
    logic signed [18:0]  rad;
    logic [31:0]         bitv;
    logic [31:0]         sum;
    logic [17:0]         t;
    logic [16:0]         mag;
    logic [30:0]         dvd;
    logic [15:0]         qv;
    logic [15:0]         c [3];
    logic [16:0]         qinc;
    logic                qb;

    // Advance when empty or when downstream takes the held beat
    assign o_rdy  = !r_vld || i_rdy;
    assign o_vld  = r_vld;
    assign o_data = r_data;

    always_comb begin
        n_data = i_data;
        trace  = '0;
        rad    = '0;
        bitv   = '0;
        sum    = '0;
        t      = '0;
        mag    = '0;
        dvd    = '0;
        qv     = '0;
        qinc   = '0;
        qb     = 1'b0;
        for (int k = 0; k < 9; k++) m[k] = i_mat[k];
        for (int k = 0; k < 3; k++) c[k] = '0;
        case (KIND)
            KIND_PREP: begin
                // Pick branch, form radicand and numerators
                n_data = '0;
                trace  = 18'(m[0]) + 18'(m[4]) + 18'(m[8]);
                if (trace > 0) begin
                    n_data.sel = SEL_W;
                    rad = 19'sd16384 + 19'(trace);
                    n_data.num[0] = 17'(m[5]) - 17'(m[7]);
                    n_data.num[1] = 17'(m[6]) - 17'(m[2]);
                    n_data.num[2] = 17'(m[1]) - 17'(m[3]);
                end else if (m[0] > m[4] && m[0] > m[8]) begin
                    n_data.sel = SEL_X;
                    rad = 19'sd16384 + 19'(m[0]) - 19'(m[4]) - 19'(m[8]);
                    n_data.num[0] = 17'(m[1]) + 17'(m[3]);
                    n_data.num[1] = 17'(m[2]) + 17'(m[6]);
                    n_data.num[2] = 17'(m[5]) - 17'(m[7]);
                end else if (m[4] > m[8]) begin
                    n_data.sel = SEL_Y;
                    rad = 19'sd16384 + 19'(m[4]) - 19'(m[0]) - 19'(m[8]);
                    n_data.num[0] = 17'(m[1]) + 17'(m[3]);
                    n_data.num[1] = 17'(m[5]) + 17'(m[7]);
                    n_data.num[2] = 17'(m[6]) - 17'(m[2]);
                end else begin
                    n_data.sel = SEL_Z;
                    rad = 19'sd16384 + 19'(m[8]) - 19'(m[0]) - 19'(m[4]);
                    n_data.num[0] = 17'(m[2]) + 17'(m[6]);
                    n_data.num[1] = 17'(m[5]) + 17'(m[7]);
                    n_data.num[2] = 17'(m[1]) - 17'(m[3]);
                end
                n_data.degen  = rad[18] || (rad == '0);
                n_data.sq_rem = n_data.degen ? '0 : {1'b0, rad[16:0], 14'b0};
            end
            KIND_SQRT: begin
                // Four bit-pair steps of the integer square root
                for (int j = 0; j < STEPS; j++) begin
                    bitv = 32'd1 << (2 * (15 - STEPS * STEP - j));
                    sum  = n_data.sq_res + bitv;
                    if (n_data.sq_rem >= sum) begin
                        n_data.sq_rem = n_data.sq_rem - sum;
                        n_data.sq_res = (n_data.sq_res >> 1) + bitv;
                    end else begin
                        n_data.sq_res = n_data.sq_res >> 1;
                    end
                end
            end
            KIND_DSET: begin
                // Divisor 2q, half root, rounded dividends and overflow check
                qinc        = {1'b0, i_data.sq_res[15:0]} + 17'd1;
                n_data.half = qinc[16:1];
                n_data.dv   = {i_data.sq_res[15:0], 1'b0};
                for (int k = 0; k < 3; k++) begin
                    n_data.neg[k] = i_data.num[k][16];
                    mag = i_data.num[k][16] ? 17'(-i_data.num[k]) : i_data.num[k];
                    dvd = {mag, 14'b0} + {15'b0, i_data.sq_res[15:0]};
                    n_data.ovf[k] = {2'b0, dvd[30:16]} >= n_data.dv;
                    n_data.rem[k] = {2'b0, dvd[30:16]};
                    n_data.lo[k]  = dvd[15:0];
                end
            end
            KIND_DIV: begin
                // Four restoring quotient bits per divider
                for (int k = 0; k < 3; k++) begin
                    for (int j = 0; j < STEPS; j++) begin
                        t  = {n_data.rem[k], n_data.lo[k][15]};
                        qb = t >= {1'b0, n_data.dv};
                        n_data.rem[k] = qb ? 17'(t - {1'b0, n_data.dv}) : t[16:0];
                        n_data.lo[k]  = {n_data.lo[k][14:0], qb};
                    end
                end
            end
            KIND_OUT: begin
                // Sign, saturate and place the components
                for (int k = 0; k < 3; k++) begin
                    qv = i_data.lo[k];
                    if (i_data.neg[k]) begin
                        c[k] = (i_data.ovf[k] || qv > 16'd32768) ? 16'h8000 : 16'(-qv);
                    end else begin
                        c[k] = (i_data.ovf[k] || qv > 16'd32767) ? 16'h7fff : qv;
                    end
                end
                if (i_data.degen) begin
                    n_data.qo = {ONE_Q14, 16'h0, 16'h0, 16'h0};
                end else begin
                    case (i_data.sel)
                        SEL_W:   n_data.qo = {i_data.half, c[2], c[1], c[0]};
                        SEL_X:   n_data.qo = {c[2], c[1], c[0], i_data.half};
                        SEL_Y:   n_data.qo = {c[2], c[1], i_data.half, c[0]};
                        SEL_Z:   n_data.qo = {c[2], i_data.half, c[1], c[0]};
                        default: n_data.qo = {ONE_Q14, 16'h0, 16'h0, 16'h0};
                    endcase
                end
            end
            default: n_data = i_data;
        endcase
    end

    // Stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy) begin
            r_data <= n_data;
        end
    end

endmodule

FILE: sv/rotation_matrix_to_quaternion.sv
// Streaming rotation matrix to quaternion converter, top level.
// Depends on rmq_pkg and rmq_stage.
//
// Takes one 3x3 matrix (Q2.14) per beat and returns one quaternion per beat.
// The root goes to w when the trace is positive, otherwise to the component
// of the largest diagonal element. The pipeline has eleven register stages:
// branch select, four square root stages, divider setup, four stages of three
// parallel restoring dividers, and output formatting. A new matrix is taken
// every cycle while o_s_axis_tready is high. Each stage holds its beat on its
// own when stalled, so bubbles close up behind a stalled output. A radicand of
// zero or less sets tuser (degenerate) and returns the identity quaternion.
module rotation_matrix_to_quaternion (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // m11, m12, m13, m21, m22, m23, m31, m32, m33 from bit 0 up, 16 bits each
    input  logic [143:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // qx, qy, qz, qw from bit 0 up, 16 bits each
    output logic [63:0] o_m_axis_tdata,
    // degenerate
    output logic        o_m_axis_tuser
);
    import rmq_pkg::*;

    logic               w_vld [NUM_STAGES+1];
    logic               w_rdy [NUM_STAGES+1];
    t_pipe              w_data [NUM_STAGES+1];
    logic [8:0][15:0]   w_mat;

    assign w_mat           = i_s_axis_tdata;
    assign w_vld[0]        = i_s_axis_tvalid;
    assign w_data[0]       = '0;
    assign o_s_axis_tready = w_rdy[0];

    // Chain of stages
    for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
        localparam int KIND = (s == 0) ? KIND_PREP :
                              (s <= SQRT_STAGES) ? KIND_SQRT :
                              (s == SQRT_STAGES + 1) ? KIND_DSET :
                              (s <= SQRT_STAGES + 1 + DIV_STAGES) ? KIND_DIV : KIND_OUT;
        localparam int STEP = (KIND == KIND_SQRT) ? s - 1 : 0;
        rmq_stage #(
            .KIND (KIND),
            .STEP (STEP)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_vld[s]),
            .o_rdy   (w_rdy[s]),
            .i_data  (w_data[s]),
            .i_mat   (w_mat),
            .o_vld   (w_vld[s+1]),
            .i_rdy   (w_rdy[s+1]),
            .o_data  (w_data[s+1])
        );
    end

    assign w_rdy[NUM_STAGES] = i_m_axis_tready;
    assign o_m_axis_tvalid   = w_vld[NUM_STAGES];
    assign o_m_axis_tdata    = w_data[NUM_STAGES].qo;
    assign o_m_axis_tuser    = w_data[NUM_STAGES].degen;

    // Degenerate beats carry the identity quaternion
    a_degen_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == {ONE_Q14, 48'h0})
        else $error("degenerate beat without identity quaternion");

    // Positive trace never leads to a zero radicand
    a_trace_nondegen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vld[1] && w_data[1].sel == SEL_W |-> !w_data[1].degen)
        else $error("trace branch marked degenerate");

    // A degenerate item leaves the root at zero
    a_degen_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vld[SQRT_STAGES+1] && w_data[SQRT_STAGES+1].degen
            |-> w_data[SQRT_STAGES+1].sq_res == '0)
        else $error("degenerate item produced a nonzero root");

endmodule

FILE: verif/testbench.sv
// Testbench for the rotation matrix to quaternion stream converter.
// Depends on rmq_pkg and rotation_matrix_to_quaternion; predicts each quaternion in-line.
`timescale 1ns / 1ps

module testbench;
    import rmq_pkg::*;

    typedef struct packed {
        logic [15:0] qw, qz, qy, qx;
        logic        degen;
    } t_quat;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [143:0] i_s_axis_tdata;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [63:0]  o_m_axis_tdata;
    logic         o_m_axis_tuser;

    t_quat quat_q[$];
    int    mismatches;
    bit    gaps_on;

    rotation_matrix_to_quaternion dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Timeout well beyond the slowest correct run
    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [15:0] sat_q14(longint v);
        if (v > 32767) return 16'h7fff;
        if (v < -32768) return 16'h8000;
        return v[15:0];
    endfunction

    // Integer floor square root
    function automatic longint root_floor(longint v);
        longint r;
        r = 0;
        for (int b = 31; b >= 0; b--)
            if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= v)
                r = r + (longint'(1) << b);
        return r;
    endfunction

    // n * 16384 / d, rounded to nearest, ties away from zero
    function automatic logic [15:0] scale_div(longint n, longint d);
        longint mag, r;
        mag = (n < 0) ? -n : n;
        r = (mag * 16384 + d / 2) / d;
        return sat_q14((n < 0) ? -r : r);
    endfunction

    function automatic t_quat quat_of(logic [143:0] mat);
        longint m[9];
        longint tr, rad, n0, n1, n2, q, d, half;
        t_sel   sel;
        t_quat  r;
        for (int i = 0; i < 9; i++) m[i] = longint'($signed(mat[i*16 +: 16]));
        tr = m[0] + m[4] + m[8];
        if (tr > 0) begin
            sel = SEL_W; rad = 16384 + tr;
            n0 = m[5] - m[7]; n1 = m[6] - m[2]; n2 = m[1] - m[3];
        end else if (m[0] > m[4] && m[0] > m[8]) begin
            sel = SEL_X; rad = 16384 + m[0] - m[4] - m[8];
            n0 = m[1] + m[3]; n1 = m[2] + m[6]; n2 = m[5] - m[7];
        end else if (m[4] > m[8]) begin
            sel = SEL_Y; rad = 16384 + m[4] - m[0] - m[8];
            n0 = m[1] + m[3]; n1 = m[5] + m[7]; n2 = m[6] - m[2];
        end else begin
            sel = SEL_Z; rad = 16384 + m[8] - m[0] - m[4];
            n0 = m[2] + m[6]; n1 = m[5] + m[7]; n2 = m[1] - m[3];
        end
        r = '0;
        if (rad <= 0) begin
            r.qw = ONE_Q14;
            r.degen = 1'b1;
            return r;
        end
        q = root_floor(rad * 16384);
        d = 2 * q;
        half = (q + 1) >>> 1;
        case (sel)
            SEL_W: begin
                r.qx = scale_div(n0, d); r.qy = scale_div(n1, d);
                r.qz = scale_div(n2, d); r.qw = sat_q14(half);
            end
            SEL_X: begin
                r.qx = sat_q14(half); r.qy = scale_div(n0, d);
                r.qz = scale_div(n1, d); r.qw = scale_div(n2, d);
            end
            SEL_Y: begin
                r.qy = sat_q14(half); r.qx = scale_div(n0, d);
                r.qz = scale_div(n1, d); r.qw = scale_div(n2, d);
            end
            default: begin
                r.qz = sat_q14(half); r.qx = scale_div(n0, d);
                r.qy = scale_div(n1, d); r.qw = scale_div(n2, d);
            end
        endcase
        return r;
    endfunction

    // Send one matrix beat, with an optional random gap ahead of it
    task automatic send_matrix(logic [143:0] mat);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= mat;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        quat_q = {quat_q, quat_of(mat)};
        @(negedge i_clk);
    endtask

    // Drop valid and wait for a falling clock edge
    task automatic go_idle();
        i_s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [143:0] pack_mat(int e[9]);
        logic [143:0] v;
        for (int i = 0; i < 9; i++) v[i*16 +: 16] = e[i][15:0];
        return v;
    endfunction

    // Random rotation-like matrix: diagonal shaped to steer the branch
    function automatic logic [143:0] shaped_mat(int br);
        int e[9];
        for (int i = 0; i < 9; i++) e[i] = $urandom_range(0, 32767) - 16384;
        case (br)
            0: begin e[0] = $urandom_range(0, 16384); e[4] = $urandom_range(0, 16384);
                     e[8] = $urandom_range(0, 16384); end
            1: begin e[0] = $urandom_range(0, 16384); e[4] = -$urandom_range(0, 16384);
                     e[8] = -$urandom_range(0, 16384); end
            2: begin e[4] = $urandom_range(0, 16384); e[0] = -$urandom_range(0, 16384);
                     e[8] = -$urandom_range(0, 16384); end
            default: begin e[8] = $urandom_range(0, 16384); e[0] = -$urandom_range(0, 16384);
                     e[4] = -$urandom_range(0, 16384); end
        endcase
        return pack_mat(e);
    endfunction

    // Check each quaternion beat against the oldest prediction
    always @(posedge i_clk) begin
        t_quat exp_q, got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = {o_m_axis_tdata[63:48], o_m_axis_tdata[47:32],
                   o_m_axis_tdata[31:16], o_m_axis_tdata[15:0], o_m_axis_tuser};
            if (quat_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat %h", got);
            end else begin
                exp_q = quat_q.pop_front();
                if (got !== exp_q) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("mismatch: exp x=%h y=%h z=%h w=%h dg=%b ",
                            exp_q.qx, exp_q.qy, exp_q.qz, exp_q.qw, exp_q.degen);
                        $display("got x=%h y=%h z=%h w=%h dg=%b",
                            got.qx, got.qy, got.qz, got.qw, got.degen);
                    end
                end
            end
        end
    end

    // Receiver stalls in random bursts while gaps are on
    initial begin
        i_m_axis_tready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (gaps_on && $urandom_range(0, 5) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge i_clk);
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Extremes, every branch and ties
    task automatic test_directed();
        int e[9];
        int tests[17][9] = '{
            '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384},
            '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384},
            '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384},
            '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384},
            '{0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768},
            '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767},
            '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768},
            '{-16384, 32767, 32767, -32768, -16384, 32767, -32768, -32768, 0},
            '{100, 5, 7, 9, 100, 3, 1, 2, 100},
            '{-100, 0, 0, 0, -100, 0, 0, 0, -100},
            '{5, 1, 2, 3, 5, 4, 5, 6, -20},
            '{-20, 1, 2, 3, 5, 4, 5, 6, 5},
            '{-32768, 32767, 32767, 32767, -32768, 32767, 32767, 32767, 16384},
            '{0, 16384, 0, -16384, 0, 0, 0, 0, -16384},
            '{-8192, 1, -1, 1, -8192, -1, 1, -1, -8192},
            '{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384}
        };
        foreach (tests[i]) begin
            for (int k = 0; k < 9; k++) e[k] = tests[i][k];
            send_matrix(pack_mat(e));
        end
        go_idle();
    endtask

    // Hold the sender until every prediction has been checked
    task automatic test_drain_pause();
        while (quat_q.size() != 0) @(negedge i_clk);
        send_matrix(shaped_mat(0));
        go_idle();
    endtask

    task automatic test_random(int n);
        logic [143:0] v;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                for (int k = 0; k < 9; k++) v[k*16 +: 16] = 16'($urandom());
            end else begin
                v = shaped_mat($urandom_range(0, 3));
            end
            send_matrix(v);
        end
        go_idle();
    endtask

    initial begin
        int guard;
        mismatches      = 0;
        gaps_on         = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        gaps_on = 1'b1;
        test_directed();
        test_random(600);
        test_drain_pause();
        test_random(600);
        gaps_on = 1'b0;
        test_random(130);
        guard = 0;
        while (quat_q.size() != 0 && guard < 10000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (20) @(negedge i_clk);
        if (mismatches == 0 && quat_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

FILE: files.f
sv/rmq_pkg.sv
sv/rmq_stage.sv
sv/rotation_matrix_to_quaternion.sv
verif/testbench.sv
